>>> rtl/fmsf_pkg.sv
`default_nettype none

package fmsf_pkg;

    // Width of the stored timestamp and of the event counter.
    localparam int TIME_BITS  = 48;
    localparam int EVENT_BITS = 32;

    // Fixed field widths of the request and result.
    localparam int TS_W    = 48;
    localparam int SEQ_W   = 64;
    localparam int FLAGS_W = 16;
    localparam int MODE_W  = 4;
    localparam int EVNUM_W = 32;

    // Request kinds.
    localparam logic REQ_OBSERVE = 1'b0;
    localparam logic REQ_COMMAND = 1'b1;

    // Bit positions in the observation flags.
    localparam int FLG_FATAL      = 0;
    localparam int FLG_HB_TIMEOUT = 1;
    localparam int FLG_HEALTH_OK  = 2;
    localparam int FLG_LOCKED     = 3;
    localparam int FLG_OP_MODE    = 4;
    localparam int FLG_APPR_TO    = 5;
    localparam int FLG_PREFLIGHT  = 6;
    localparam int FLG_MISSION    = 7;
    localparam int FLG_AUTO       = 8;
    localparam int FLG_ARMED      = 9;
    localparam int FLG_ALTITUDE   = 10;
    localparam int FLG_TGT_CONF   = 11;
    localparam int FLG_LANDING    = 12;
    localparam int FLG_TGT_LOSS   = 13;
    localparam int FLG_LOSS_TO    = 14;
    localparam int FLG_DISARMED   = 15;

    typedef struct packed {
        logic                 req_type;
        logic [TS_W-1:0]      time_stamp;
        logic [SEQ_W-1:0]     seq_number;
        logic [FLAGS_W-1:0]   obs_flags;
        logic [MODE_W-1:0]    requested_state;
    } req_t;

    typedef struct packed {
        logic                 input_accepted;
        logic                 state_changed;
        logic [MODE_W-1:0]    prior_state;
        logic [MODE_W-1:0]    present_state;
        logic [EVNUM_W-1:0]   event_number;
        logic                 hover_latched;
    } rsp_t;

endpackage

`default_nettype wire

>>> rtl/fmsf_in_reg.sv
`default_nettype none

module fmsf_in_reg
    import fmsf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req_data,
    input  wire logic take,
    output logic      hold_valid,
    output req_t      hold_data
);

    logic hold_valid_reg;
    logic hold_valid_next;
    req_t hold_data_reg;

    // The held request can only leave when the result side takes it.
    assign req_stall = hold_valid_reg && !take;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (!req_stall)
        begin
            hold_valid_next = req_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            hold_data_reg <= req_data;
        end
    end

    assign hold_valid = hold_valid_reg;
    assign hold_data  = hold_data_reg;

endmodule

`default_nettype wire

>>> rtl/fmsf_core.sv
`default_nettype none

module fmsf_core
    import fmsf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic commit,
    input  wire req_t item,
    output rsp_t      result
);

    typedef enum logic [MODE_W-1:0] {
        MODE_WAIT      = 4'd0,
        MODE_TAKEOFF   = 4'd1,
        MODE_SEARCH    = 4'd2,
        MODE_GUIDED    = 4'd3,
        MODE_LOSSHOVER = 4'd4,
        MODE_SAFEHOVER = 4'd5,
        MODE_LANDING   = 4'd6,
        MODE_DISARMED  = 4'd7,
        MODE_FAILED    = 4'd8
    } mode_t;

    // Any code above FAILED means the observation asks for nothing.
    localparam logic [MODE_W-1:0] TARGET_NONE = '1;

    mode_t                 mode_reg;
    mode_t                 mode_next;
    logic [SEQ_W-1:0]      last_seq_reg;
    logic [SEQ_W-1:0]      last_seq_next;
    logic [TIME_BITS-1:0]  last_time_reg;
    logic [TIME_BITS-1:0]  last_time_next;
    logic [EVENT_BITS-1:0] event_cnt_reg;
    logic [EVENT_BITS-1:0] event_cnt_next;
    logic                  hover_reg;
    logic                  hover_next;

    logic [TIME_BITS-1:0]  ts;
    logic [FLAGS_W-1:0]    f;
    logic                  accepted;
    logic                  fault;
    logic [MODE_W-1:0]     obs_target;
    logic [MODE_W-1:0]     target;
    logic                  move_ok;
    logic                  changed;

    assign ts = item.time_stamp[TIME_BITS-1:0];
    assign f  = item.obs_flags;

    assign accepted = ((item.seq_number == '0) || (item.seq_number > last_seq_reg)) &&
                      ((last_time_reg == '0) || (ts >= last_time_reg));

    assign fault = f[FLG_HB_TIMEOUT] || !f[FLG_HEALTH_OK] || f[FLG_LOCKED] ||
                   f[FLG_OP_MODE] || f[FLG_APPR_TO];

    always_comb
    begin
        obs_target = TARGET_NONE;
        if (f[FLG_FATAL] && (mode_reg != MODE_DISARMED))
        begin
            obs_target = MODE_FAILED;
        end
        else
        begin
            case (mode_reg)
                MODE_WAIT:
                begin
                    if (fault)
                        obs_target = MODE_SAFEHOVER;
                    else if (f[FLG_PREFLIGHT] && f[FLG_MISSION] && f[FLG_AUTO] && f[FLG_ARMED])
                        obs_target = MODE_TAKEOFF;
                end
                MODE_TAKEOFF:
                begin
                    if (fault)
                        obs_target = MODE_SAFEHOVER;
                    else if (f[FLG_ALTITUDE])
                        obs_target = MODE_SEARCH;
                end
                MODE_SEARCH:
                begin
                    if (fault)
                        obs_target = MODE_SAFEHOVER;
                    else if (f[FLG_TGT_CONF])
                        obs_target = MODE_GUIDED;
                end
                MODE_GUIDED:
                begin
                    if (fault)
                        obs_target = MODE_SAFEHOVER;
                    else if (f[FLG_LANDING])
                        obs_target = MODE_LANDING;
                    else if (f[FLG_TGT_LOSS])
                        obs_target = MODE_LOSSHOVER;
                end
                MODE_LOSSHOVER:
                begin
                    if (fault || f[FLG_LOSS_TO])
                        obs_target = MODE_SAFEHOVER;
                    else if (f[FLG_LANDING])
                        obs_target = MODE_LANDING;
                    else if (f[FLG_TGT_CONF])
                        obs_target = MODE_GUIDED;
                end
                MODE_SAFEHOVER:
                begin
                    if (f[FLG_LANDING])
                        obs_target = MODE_LANDING;
                    else if (f[FLG_DISARMED])
                        obs_target = MODE_DISARMED;
                end
                MODE_LANDING:
                begin
                    if (f[FLG_DISARMED])
                        obs_target = MODE_DISARMED;
                end
                default:
                begin
                    obs_target = TARGET_NONE;
                end
            endcase
        end
    end

    assign target = (item.req_type == REQ_COMMAND) ? item.requested_state : obs_target;

    // Out-of-range codes, a move to the present mode and anything out of
    // safe hover other than landing or disarming are all refused.
    assign move_ok = (target <= MODE_FAILED) && (target != mode_reg) &&
                     ((mode_reg != MODE_SAFEHOVER) || (target == MODE_LANDING) ||
                      (target == MODE_DISARMED));

    assign changed = accepted && move_ok;

    always_comb
    begin
        mode_next      = mode_reg;
        last_seq_next  = last_seq_reg;
        last_time_next = last_time_reg;
        event_cnt_next = event_cnt_reg;
        hover_next     = hover_reg;
        if (accepted)
        begin
            last_time_next = ts;
            if (item.seq_number != '0)
            begin
                last_seq_next = item.seq_number;
            end
        end
        if (changed)
        begin
            mode_next      = mode_t'(target);
            event_cnt_next = event_cnt_reg + EVENT_BITS'(1);
            if (target == MODE_SAFEHOVER)
            begin
                hover_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_WAIT;
            last_seq_reg  <= '0;
            last_time_reg <= '0;
            event_cnt_reg <= EVENT_BITS'(1);
            hover_reg     <= 1'b0;
        end
        else if (commit)
        begin
            mode_reg      <= mode_next;
            last_seq_reg  <= last_seq_next;
            last_time_reg <= last_time_next;
            event_cnt_reg <= event_cnt_next;
            hover_reg     <= hover_next;
        end
    end

    always_comb
    begin
        result.input_accepted = accepted;
        result.state_changed  = changed;
        result.prior_state    = mode_reg;
        result.present_state  = mode_next;
        result.event_number   = changed ? EVNUM_W'(event_cnt_reg) : '0;
        result.hover_latched  = hover_next;
    end

endmodule

`default_nettype wire

>>> rtl/flight_mode_safety_fsm.sv
// Flight-mode supervisor with nine modes.
// Requests arrive on req_valid / req_stall / req_data. Each request is an
// observation step carrying sixteen status flags or a commanded move to a
// requested mode; both carry a timestamp and a sequence number. Every request
// yields exactly one result on rsp_valid / rsp_stall / rsp_data, in order.
// A request is taken at a rising edge with req_valid high and req_stall low.
// It lands in an input register, is judged there by the sequence and
// timestamp checks and the mode logic, and its result is registered once
// the result register can take it. Throughput is one request per cycle
// while the receiver does not stall; the supervisor state (mode, last
// sequence, last timestamp, event counter, safe hover latch) updates in the
// same cycle the result is registered, so back-to-back requests see it.
// When the receiver asserts rsp_stall the result register holds its value,
// the input register fills and then req_stall rises until the result is taken.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// supervisor to the waiting mode with the event counter at one and the latch
// clear.
`default_nettype none

module flight_mode_safety_fsm
    import fmsf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req_data,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp_data
);

    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_data_reg;
    logic out_ready;
    logic hold_valid;
    req_t hold_data;
    logic commit;
    rsp_t result;

    // The result register can take a new value when it is empty or being read.
    assign out_ready = !rsp_valid_reg || !rsp_stall;
    assign commit    = hold_valid && out_ready;

    fmsf_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .take       (out_ready),
        .hold_valid (hold_valid),
        .hold_data  (hold_data)
    );

    fmsf_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .item   (hold_data),
        .result (result)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_ready)
        begin
            rsp_valid_next = hold_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

>>> verif/fmsf_tb_pkg.sv
`default_nettype none

package fmsf_tb_pkg;

    import fmsf_pkg::*;

    // Flight modes in the encoding used by requested_state and the result.
    typedef enum logic [MODE_W-1:0] {
        MODE_WAIT        = 4'd0,
        MODE_TAKEOFF     = 4'd1,
        MODE_SEARCH      = 4'd2,
        MODE_GUIDED      = 4'd3,
        MODE_LOSS_HOVER  = 4'd4,
        MODE_SAFE_HOVER  = 4'd5,
        MODE_LANDING     = 4'd6,
        MODE_DISARMED    = 4'd7,
        MODE_FAILED      = 4'd8
    } mode_e;

    // A mode code beyond the last valid one; also marks "no move wanted".
    localparam logic [MODE_W-1:0] NO_MOVE = 4'hF;

endpackage

`default_nettype wire

>>> verif/fmsf_supervisor_check.sv
`default_nettype none

module fmsf_supervisor_check
    import fmsf_pkg::*;
    import fmsf_tb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire logic req_stall,
    input  wire req_t req_data,
    input  wire logic rsp_valid,
    input  wire logic rsp_stall,
    input  wire rsp_t rsp_data,
    output int        fail_count,
    output int        pending
);

    // Shadow copy of the supervisor state.
    mode_e                  cur_mode;
    logic [SEQ_W-1:0]       seen_seq;
    logic [TIME_BITS-1:0]   seen_ts;
    logic [EVENT_BITS-1:0]  next_event;
    logic                   hover_seen;

    rsp_t                   outcome_q[$];

    function automatic logic fault_seen(input logic [FLAGS_W-1:0] f);
        return f[FLG_HB_TIMEOUT] || !f[FLG_HEALTH_OK] || f[FLG_LOCKED] ||
               f[FLG_OP_MODE] || f[FLG_APPR_TO];
    endfunction

    // Mode that an observation asks for, or NO_MOVE.
    function automatic logic [MODE_W-1:0] observed_target(input mode_e m,
                                                          input logic [FLAGS_W-1:0] f);
        if (f[FLG_FATAL] && m != MODE_DISARMED)
            return MODE_FAILED;
        case (m)
            MODE_WAIT:
            begin
                if (fault_seen(f))
                    return MODE_SAFE_HOVER;
                if (f[FLG_PREFLIGHT] && f[FLG_MISSION] && f[FLG_AUTO] && f[FLG_ARMED])
                    return MODE_TAKEOFF;
            end
            MODE_TAKEOFF:
            begin
                if (fault_seen(f))
                    return MODE_SAFE_HOVER;
                if (f[FLG_ALTITUDE])
                    return MODE_SEARCH;
            end
            MODE_SEARCH:
            begin
                if (fault_seen(f))
                    return MODE_SAFE_HOVER;
                if (f[FLG_TGT_CONF])
                    return MODE_GUIDED;
            end
            MODE_GUIDED:
            begin
                if (fault_seen(f))
                    return MODE_SAFE_HOVER;
                if (f[FLG_LANDING])
                    return MODE_LANDING;
                if (f[FLG_TGT_LOSS])
                    return MODE_LOSS_HOVER;
            end
            MODE_LOSS_HOVER:
            begin
                if (fault_seen(f) || f[FLG_LOSS_TO])
                    return MODE_SAFE_HOVER;
                if (f[FLG_LANDING])
                    return MODE_LANDING;
                if (f[FLG_TGT_CONF])
                    return MODE_GUIDED;
            end
            MODE_SAFE_HOVER:
            begin
                if (f[FLG_LANDING])
                    return MODE_LANDING;
                if (f[FLG_DISARMED])
                    return MODE_DISARMED;
            end
            MODE_LANDING:
            begin
                if (f[FLG_DISARMED])
                    return MODE_DISARMED;
            end
            default:
            begin
            end
        endcase
        return NO_MOVE;
    endfunction

    // Works out the result of one request and advances the shadow state.
    function automatic rsp_t predict_outcome(input req_t r);
        rsp_t               o;
        logic               ok;
        logic [MODE_W-1:0]  target;
        o = '0;
        o.prior_state = cur_mode;
        ok = !((r.seq_number != '0 && r.seq_number <= seen_seq) ||
               (seen_ts != '0 && r.time_stamp[TIME_BITS-1:0] < seen_ts));
        if (ok)
        begin
            if (r.seq_number != '0)
                seen_seq = r.seq_number;
            seen_ts = r.time_stamp[TIME_BITS-1:0];
            target = (r.req_type == REQ_COMMAND) ? r.requested_state
                                                 : observed_target(cur_mode, r.obs_flags);
            if (target <= MODE_FAILED && target != cur_mode &&
                (cur_mode != MODE_SAFE_HOVER || target == MODE_LANDING ||
                 target == MODE_DISARMED))
            begin
                o.state_changed = 1'b1;
                o.event_number  = next_event;
                next_event      = next_event + 1'b1;
                cur_mode        = mode_e'(target);
                if (cur_mode == MODE_SAFE_HOVER)
                    hover_seen = 1'b1;
            end
        end
        o.input_accepted = ok;
        o.present_state  = cur_mode;
        o.hover_latched  = hover_seen;
        return o;
    endfunction

    task automatic check_field(input string fname, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            cur_mode   = MODE_WAIT;
            seen_seq   = '0;
            seen_ts    = '0;
            next_event = EVENT_BITS'(1);
            hover_seen = 1'b0;
            outcome_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result with no request outstanding: %h", rsp_data);
                    fail_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("input_accepted", 64'(want.input_accepted),
                                64'(rsp_data.input_accepted));
                    check_field("state_changed", 64'(want.state_changed),
                                64'(rsp_data.state_changed));
                    check_field("prior_state", 64'(want.prior_state),
                                64'(rsp_data.prior_state));
                    check_field("present_state", 64'(want.present_state),
                                64'(rsp_data.present_state));
                    check_field("event_number", 64'(want.event_number),
                                64'(rsp_data.event_number));
                    check_field("hover_latched", 64'(want.hover_latched),
                                64'(rsp_data.hover_latched));
                end
            end
            if (req_valid && !req_stall)
                outcome_q = {outcome_q, predict_outcome(req_data)};
            pending = outcome_q.size();
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_flight_mode_safety_fsm.sv
`default_nettype none

// Top of the supervisor testbench. It makes the request stream, drives the
// result stall and gives the verdict; the checker beside the block does all
// prediction and comparison.
module tb_flight_mode_safety_fsm;

    import fmsf_pkg::*;
    import fmsf_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    // Watchdog bound on the whole run; this is ample.
    localparam int CYCLE_LIMIT  = 200000;
    // Length of the one long hold-off on the result side.
    localparam int HOLD_CYCLES  = 80;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    req_t               req_data  = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    rsp_t               rsp_data;

    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;
    int                 burst_left  = 0;
    bit                 hold_go     = 1'b0;

    // Highest sequence number and timestamp ever offered. Any request built
    // above these is certain to pass the ordering checks, whatever was
    // accepted before.
    logic [SEQ_W-1:0]   top_seq = '0;
    logic [TS_W-1:0]    top_ts  = '0;

    always #1 clk = ~clk;

    flight_mode_safety_fsm i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    fmsf_supervisor_check i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Healthy flags with one extra flag raised.
    function automatic logic [FLAGS_W-1:0] healthy_with(input int flag_pos);
        logic [FLAGS_W-1:0] f;
        f = '0;
        f[FLG_HEALTH_OK] = 1'b1;
        f[flag_pos] = 1'b1;
        return f;
    endfunction

    // A sequence number that is sure to be accepted. Zero (unsequenced) is
    // mixed in, and is also the way out once the counter nears its top.
    function automatic logic [SEQ_W-1:0] next_seq();
        if ($urandom_range(0, 7) == 0 || top_seq > {SEQ_W{1'b1}} - 16)
            return '0;
        return top_seq + $urandom_range(1, 4);
    endfunction

    // A timestamp that is never below any one offered so far; repeats of the
    // same time are allowed and happen often.
    function automatic logic [TS_W-1:0] next_ts();
        if (top_ts > {TS_W{1'b1}} - 8)
            return top_ts;
        return top_ts + $urandom_range(0, 3);
    endfunction

    // Status flags for a plausible flight: mostly healthy, progress flags at
    // random, faults and the fatal flag now and then.
    function automatic logic [FLAGS_W-1:0] flight_flags();
        logic [FLAGS_W-1:0] f;
        f = FLAGS_W'($urandom);
        f[FLG_FATAL]      = ($urandom_range(0, 59) == 0);
        f[FLG_HB_TIMEOUT] = ($urandom_range(0, 59) == 0);
        f[FLG_HEALTH_OK]  = ($urandom_range(0, 59) != 0);
        f[FLG_LOCKED]     = ($urandom_range(0, 59) == 0);
        f[FLG_OP_MODE]    = ($urandom_range(0, 59) == 0);
        f[FLG_APPR_TO]    = ($urandom_range(0, 59) == 0);
        f[FLG_LOSS_TO]    = ($urandom_range(0, 4) == 0);
        f[FLG_DISARMED]   = ($urandom_range(0, 4) == 0);
        return f;
    endfunction

    // Offers one request and returns at the edge where it is taken. The
    // sender works in bursts; between bursts valid drops for a random gap,
    // and sometimes not at all so that requests also come back to back.
    task automatic send(input logic kind, input logic [TS_W-1:0] ts,
                        input logic [SEQ_W-1:0] seq, input logic [FLAGS_W-1:0] flags,
                        input logic [MODE_W-1:0] target);
        int gap;
        if (seq > top_seq)
            top_seq = seq;
        if (ts > top_ts)
            top_ts = ts;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            repeat (gap)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= '{req_type: kind, time_stamp: ts, seq_number: seq,
                       obs_flags: flags, requested_state: target};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Result side. The stall rate changes from one stretch to the next,
    // including stretches with no stall at all. Once the stimulus asks for
    // it, the stall is held for a long stretch so that the block fills up
    // and has to stall incoming requests.
    initial
    begin
        int  mode_left;
        int  stall_pct;
        int  hold_left;
        bit  held;
        mode_left = 0;
        stall_pct = 0;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !held)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Watchdog: a hung handshake or a result that never comes ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[flight_mode_safety_fsm] ERROR");
            $finish;
        end
    end

    initial
    begin
        int                 pick;
        logic [63:0]        wide_seq;
        logic [63:0]        wide_ts;
        logic [FLAGS_W-1:0] launch;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        launch = healthy_with(FLG_PREFLIGHT) | healthy_with(FLG_MISSION) |
                 healthy_with(FLG_AUTO) | healthy_with(FLG_ARMED);

        // Directed walk through the modes. The first request is unsequenced
        // and carries time zero, which leaves the time check disarmed.
        send(REQ_OBSERVE, 0, 0, healthy_with(FLG_MISSION), NO_MOVE);
        send(REQ_OBSERVE, 5, 1, launch, NO_MOVE);
        send(REQ_OBSERVE, 5, 2, healthy_with(FLG_ALTITUDE), NO_MOVE);
        send(REQ_OBSERVE, 6, 0, healthy_with(FLG_TGT_CONF), NO_MOVE);
        send(REQ_OBSERVE, 7, 3, healthy_with(FLG_TGT_LOSS), NO_MOVE);
        send(REQ_OBSERVE, 8, 4, healthy_with(FLG_TGT_CONF), NO_MOVE);
        send(REQ_OBSERVE, 9, 5, healthy_with(FLG_TGT_LOSS), NO_MOVE);
        // A repeated sequence number and then an older timestamp are refused.
        send(REQ_OBSERVE, 9, 5, healthy_with(FLG_LOSS_TO), NO_MOVE);
        send(REQ_OBSERVE, 4, 6, healthy_with(FLG_LOSS_TO), NO_MOVE);
        // Loss timeout drops into safe hover and sets the latch.
        send(REQ_OBSERVE, 10, 6, healthy_with(FLG_LOSS_TO), NO_MOVE);
        // From safe hover: a command elsewhere, a fatal error and a command
        // to safe hover itself are all refused.
        send(REQ_COMMAND, 11, 7, '0, MODE_GUIDED);
        send(REQ_OBSERVE, 12, 8, healthy_with(FLG_FATAL), NO_MOVE);
        send(REQ_COMMAND, 13, 9, '1, MODE_SAFE_HOVER);
        send(REQ_OBSERVE, 14, 10, healthy_with(FLG_LANDING), NO_MOVE);
        // A requested mode beyond the valid range is accepted but not taken.
        send(REQ_COMMAND, 15, 11, '0, NO_MOVE);
        send(REQ_OBSERVE, 16, 12, healthy_with(FLG_DISARMED), NO_MOVE);
        // Disarmed ignores the fatal flag.
        send(REQ_OBSERVE, 17, 13, healthy_with(FLG_FATAL), NO_MOVE);
        send(REQ_COMMAND, 18, 14, '0, MODE_FAILED);
        send(REQ_OBSERVE, 19, 15, '1, NO_MOVE);
        send(REQ_COMMAND, 20, 16, '0, MODE_WAIT);
        // Health not reported is a safety fault.
        send(REQ_OBSERVE, 21, 17, '0, NO_MOVE);
        send(REQ_COMMAND, 22, 18, '0, MODE_DISARMED);
        send(REQ_COMMAND, 23, 19, '0, MODE_WAIT);
        send(REQ_OBSERVE, 24, 20, healthy_with(FLG_FATAL), NO_MOVE);
        send(REQ_COMMAND, 25, 21, '0, MODE_WAIT);

        // Random part: mostly well-ordered requests so that the flight gets
        // deep into its modes, with commands to leave the dead ends and a
        // share of noise that is frequently out of order.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
                hold_go = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                wide_seq = $urandom_range(0, 1) ? {$urandom, $urandom} : top_seq;
                wide_ts  = {$urandom, $urandom};
                send(1'($urandom_range(0, 1)), wide_ts[TS_W-1:0], wide_seq,
                     FLAGS_W'($urandom), MODE_W'($urandom_range(0, 15)));
            end
            else if (pick < 25)
            begin
                send(REQ_COMMAND, next_ts(), next_seq(), flight_flags(),
                     ($urandom_range(0, 9) == 0) ?
                         MODE_W'($urandom_range(int'(MODE_FAILED) + 1, 15)) :
                         MODE_W'($urandom_range(0, int'(MODE_FAILED))));
            end
            else
            begin
                send(REQ_OBSERVE, next_ts(), next_seq(), flight_flags(),
                     MODE_W'($urandom_range(0, 15)));
            end
        end

        // Largest sequence number and timestamp, then the same sequence
        // number again, which must be refused.
        send(REQ_OBSERVE, '1, '1, '1, NO_MOVE);
        send(REQ_COMMAND, '1, '1, '0, MODE_WAIT);

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        // The extra wait catches any stray result.
        repeat (8) @(negedge clk);

        if (fail_count == 0)
            $display("[flight_mode_safety_fsm] OK");
        else
            $display("[flight_mode_safety_fsm] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
